// ===== hw/rtl/ctf_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt filter.
// No dependencies.
`default_nettype none
package ctf_pkg;
  localparam int CORDIC_STEPS_DEFAULT = 16;
  localparam int TABLE_LEN = 24;
  localparam logic [15:0] ALPHA_RESET = 16'd64225;
  localparam logic signed [13:0] HALF_PI_Q12 = 14'sd6434;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;       // capture inputs, start x*x
    logic mul_z;      // start z*z
    logic sum_sq;     // form x*x + z*z, prime square root
    logic sqrt_step;  // one square-root digit
    logic cordic_init;
    logic cordic_step;
    logic tilt_done;  // round and clamp tilt
    logic mul_rate;   // rate * dt
    logic sum_rate;   // acc + 2 * rate * dt
    logic mul_a;      // alpha * sum
    logic mul_b;      // (1 - alpha) * tilt
    logic blend;      // add, round, saturate, update accumulator
  } ctf_cmd_t;

  typedef struct packed {
    logic zero_mag;
  } ctf_stat_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 17'd51472;
      5'd1: atan_q16 = 17'd30385;
      5'd2: atan_q16 = 17'd16055;
      5'd3: atan_q16 = 17'd8150;
      5'd4: atan_q16 = 17'd4091;
      5'd5: atan_q16 = 17'd2047;
      5'd6: atan_q16 = 17'd1024;
      5'd7: atan_q16 = 17'd512;
      5'd8: atan_q16 = 17'd256;
      5'd9: atan_q16 = 17'd128;
      5'd10: atan_q16 = 17'd64;
      5'd11: atan_q16 = 17'd32;
      5'd12: atan_q16 = 17'd16;
      5'd13: atan_q16 = 17'd8;
      5'd14: atan_q16 = 17'd4;
      5'd15: atan_q16 = 17'd2;
      5'd16: atan_q16 = 17'd1;
      default: atan_q16 = 17'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ctf_datapath.sv =====
// Datapath of the tilt filter: shared multiplier, square root, CORDIC, blend.
// Depends on ctf_pkg.
`default_nettype none
module ctf_datapath (
  input  wire                    clk,
  input  wire                    rst,
  input  wire ctf_pkg::ctf_cmd_t cmd,
  output ctf_pkg::ctf_stat_t     stat,
  input  wire [4:0]              step_idx,
  input  wire [15:0]             alpha,
  input  wire signed [15:0]      in_x,
  input  wire signed [15:0]      in_y,
  input  wire signed [15:0]      in_z,
  input  wire signed [15:0]      in_rate,
  input  wire [15:0]             in_dt,
  output logic signed [15:0]     filtered_q,
  output logic signed [13:0]     tilt_q,
  output logic signed [15:0]     rate_q
);
  import ctf_pkg::*;

  logic signed [15:0] ry, rz;
  logic [15:0] rdt;
  logic signed [33:0] prod;     // registered multiplier output
  logic signed [33:0] prod_x;
  // square root of sumsq * 2^30: 62-bit radicand, 31-bit root, two bits a step
  logic [62:0] rem;
  logic [31:0] root;
  logic [61:0] rad;
  logic signed [35:0] cx, cy;
  logic signed [18:0] ang;
  logic signed [13:0] tilt;
  logic signed [31:0] acc;
  logic signed [33:0] sum;
  logic signed [49:0] pa;
  logic zero_mag;

  // 1 - alpha reaches 65536, so the first operand carries 18 bits
  logic signed [17:0] ma;
  logic signed [33:0] mb;
  logic signed [51:0] mprod;

  // One multiplier, operands chosen by command.
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.load)          begin ma = 18'(in_x);     mb = 34'(in_x); end
    else if (cmd.mul_z)    begin ma = 18'(rz);       mb = 34'(rz); end
    else if (cmd.mul_rate) begin ma = {2'b0, rdt};   mb = 34'(rate_q); end
    else if (cmd.mul_a)    begin ma = {2'b0, alpha}; mb = sum; end
    else if (cmd.mul_b)    begin
      ma = 18'sd65536 - $signed({2'b0, alpha});
      mb = 34'(tilt);
    end
    mprod = ma * mb;
  end

  logic [62:0] cur;
  logic [62:0] sub;
  always_comb begin
    cur = {rem[60:0], rad[61:60]};
    sub = {29'b0, root, 2'b01};
  end

  logic signed [35:0] sx, sy;
  logic [4:0] si;
  assign si = step_idx;
  assign sx = cx >>> si;
  assign sy = cy >>> si;

  logic signed [19:0] tr;
  assign tr = (20'(ang) + 20'sd8) >>> 4;

  logic signed [51:0] tot;
  logic signed [35:0] blended;
  assign tot = 52'(pa) + (52'(prod) <<< 16) + 52'sd32768;
  assign blended = 36'(tot >>> 16);

  logic signed [31:0] acc_n;
  always_comb begin
    if (blended > 36'sd2147483647) acc_n = 32'sh7fffffff;
    else if (blended < -36'sd2147483648) acc_n = 32'sh80000000;
    else acc_n = blended[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.blend) begin
      acc <= acc_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.mul_z || cmd.mul_rate || cmd.mul_a || cmd.mul_b)
      prod <= mprod[33:0];
    if (cmd.load) begin
      ry <= in_y; rz <= in_z; rate_q <= in_rate; rdt <= in_dt;
    end
    if (cmd.mul_z) prod_x <= prod;
    if (cmd.sum_sq) begin
      rad <= {32'(prod_x + prod), 30'b0};
      zero_mag <= (prod_x + prod) == 34'sd0;
      rem <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[59:0], 2'b00};
      if (cur >= sub) begin
        rem <= cur - sub;
        root <= {root[30:0], 1'b1};
      end else begin
        rem <= cur;
        root <= {root[30:0], 1'b0};
      end
    end
    if (cmd.cordic_init) begin
      cx <= 36'($signed({1'b0, root}));
      cy <= 36'(ry) <<< 15;
      ang <= '0;
    end
    if (cmd.cordic_step) begin
      if (!cy[35]) begin
        cx <= cx + sy; cy <= cy - sx; ang <= ang + 19'($signed({2'b0, atan_q16(si)}));
      end else begin
        cx <= cx - sy; cy <= cy + sx; ang <= ang - 19'($signed({2'b0, atan_q16(si)}));
      end
    end
    if (cmd.tilt_done) begin
      if (zero_mag) begin
        if (ry > 0) tilt <= HALF_PI_Q12;
        else if (ry < 0) tilt <= -HALF_PI_Q12;
        else tilt <= '0;
      end else if (tr > 20'sd6434) tilt <= HALF_PI_Q12;
      else if (tr < -20'sd6434) tilt <= -HALF_PI_Q12;
      else tilt <= tr[13:0];
    end
    // sum must be ready when mul_a multiplies it: it is formed in the cycle before
    if (cmd.sum_rate) sum <= 34'(acc) + (prod <<< 1);
    if (cmd.mul_a) pa <= mprod[49:0];
    if (cmd.blend) begin
      filtered_q <= acc_n[31:16];
      tilt_q <= tilt;
    end
  end

  assign stat.zero_mag = zero_mag;
endmodule
`default_nettype wire

// ===== hw/rtl/ctf_ctrl.sv =====
// Sequencer of the tilt filter: steps the datapath through one sample.
// Depends on ctf_pkg.
`default_nettype none
module ctf_ctrl #(
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire               out_stall,
  input  wire ctf_pkg::ctf_stat_t stat,
  output ctf_pkg::ctf_cmd_t cmd,
  output logic [4:0]        step_idx
);
  import ctf_pkg::*;
  localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam logic [3:0] S_IDLE = 4'd0, S_MULZ = 4'd1, S_SUM = 4'd2, S_SQRT = 4'd3,
    S_CINIT = 4'd4, S_CORD = 4'd5, S_TILT = 4'd6, S_RATE = 4'd7, S_SUMA = 4'd8,
    S_MA = 4'd9, S_MB = 4'd10, S_BLEND = 4'd11;

  logic [3:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic out_valid_next;

  assign step_idx = cnt;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: if (in_valid && !in_stall) begin cmd.load = 1'b1; state_next = S_MULZ; end
      S_MULZ: begin cmd.mul_z = 1'b1; state_next = S_SUM; end
      S_SUM: begin cmd.sum_sq = 1'b1; cnt_next = '0; state_next = S_SQRT; end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 5'd1;
        // zero magnitude: skip root and CORDIC, tilt is fixed by the sign of y
        if (stat.zero_mag) state_next = S_TILT;
        else if (cnt == 5'd30) state_next = S_CINIT;
      end
      S_CINIT: begin cmd.cordic_init = 1'b1; cnt_next = '0; state_next = S_CORD; end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(NSTEPS - 1)) state_next = S_TILT;
      end
      S_TILT: begin cmd.tilt_done = 1'b1; state_next = S_RATE; end
      S_RATE: begin cmd.mul_rate = 1'b1; state_next = S_SUMA; end
      S_SUMA: begin cmd.sum_rate = 1'b1; state_next = S_MA; end
      S_MA: begin cmd.mul_a = 1'b1; state_next = S_MB; end
      S_MB: begin cmd.mul_b = 1'b1; state_next = S_BLEND; end
      S_BLEND: begin cmd.blend = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; out_valid <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next; out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/complementary_tilt_filter_top.sv =====
// Top level of the complementary tilt filter.
// Depends on ctf_pkg, ctf_ctrl and ctf_datapath.
// One sample at a time: the sample passes the 31-digit square root and the CORDIC
// loop, which share one sequencer, then the serial multiplies of the blend on a
// single shared multiplier; a new sample is taken only after the last one's result
// is formed. CORDIC_STEPS above 24 runs 24 steps.
// When x and z are both zero the root and CORDIC are skipped.
// The result sits in an output register until taken; the next sample is taken
// once that register is free or being emptied.
`default_nettype none
module complementary_tilt_filter_top #(
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEFAULT
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [15:0]        cfg_wdata,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [15:0] accel_x,
  input  wire signed [15:0] accel_y,
  input  wire signed [15:0] accel_z,
  input  wire signed [15:0] rate_x,
  input  wire [15:0]        time_step,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] filtered_angle,
  output logic signed [13:0] tilt_angle,
  output logic signed [15:0] last_rate
);
  import ctf_pkg::*;
  logic [15:0] blend_weight;
  ctf_cmd_t cmd;
  ctf_stat_t stat;
  logic [4:0] step_idx;

  always_ff @(posedge clk) begin
    if (rst) blend_weight <= ALPHA_RESET;
    else if (cfg_we) blend_weight <= cfg_wdata;
  end

  ctf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd, .step_idx
  );
  ctf_datapath u_dp (
    .clk, .rst, .cmd, .stat, .step_idx, .alpha(blend_weight),
    .in_x(accel_x), .in_y(accel_y), .in_z(accel_z), .in_rate(rate_x), .in_dt(time_step),
    .filtered_q(filtered_angle), .tilt_q(tilt_angle), .rate_q(last_rate)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/ctf_checker.sv =====
// Port-level checks of the tilt filter, bound to the top level.
// Depends on complementary_tilt_filter_top.
`default_nettype none
module ctf_checker (
  input wire clk, input wire rst, input wire in_valid, input wire in_stall,
  input wire out_valid, input wire out_stall, input wire signed [13:0] tilt_angle
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tilt_angle)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second transaction taken while busy");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tilt_angle <= 14'sd6434) && (tilt_angle >= -14'sd6434))
    else $error("tilt out of range");
  a_noout: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
endmodule
bind complementary_tilt_filter_top ctf_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .tilt_angle
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the complementary tilt filter top level.
// Depends on ctf_pkg and complementary_tilt_filter_top; predicts each sample in a scoreboard class.
`timescale 1ns / 100ps
`default_nettype none

class tilt_scoreboard;
  logic [15:0] alpha;
  logic signed [31:0] acc;
  logic [15:0] exp_angle[$];
  logic [13:0] exp_tilt[$];
  logic [15:0] exp_rate[$];
  int errors;

  function new();
    alpha = ctf_pkg::ALPHA_RESET;
    acc = 0;
    errors = 0;
  endfunction

  static function longint shr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint isqrt(longint n);
    longint res, bit_w;
    res = 0;
    bit_w = longint'(1) << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  static function longint tilt_of(longint x, longint y, longint z);
    longint s, cx, cy, nx, ny, ang, t;
    longint atab[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2, 1};
    s = x * x + z * z;
    if (s == 0) return (y > 0) ? 6434 : ((y < 0) ? -6434 : 0);
    cx = isqrt(s << 30);
    cy = y * 32768;
    ang = 0;
    for (int i = 0; i < ctf_pkg::CORDIC_STEPS_DEFAULT; i++) begin
      if (cy >= 0) begin
        nx = cx + shr(cy, i);
        ny = cy - shr(cx, i);
        ang += atab[i];
      end else begin
        nx = cx - shr(cy, i);
        ny = cy + shr(cx, i);
        ang -= atab[i];
      end
      cx = nx;
      cy = ny;
    end
    t = shr(ang + 8, 4);
    if (t > 6434) t = 6434;
    if (t < -6434) t = -6434;
    return t;
  endfunction

  function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az, logic signed [15:0] rate,
                            logic [15:0] dt);
    longint tilt, sum, blend, a;
    a = longint'(alpha);
    tilt = tilt_of(ax, ay, az);
    sum = longint'(acc) + longint'(rate) * longint'(dt) * 2;
    blend = shr(a * sum + (65536 - a) * (tilt * 65536) + 32768, 16);
    if (blend > 64'sd2147483647) blend = 64'sd2147483647;
    if (blend < -64'sd2147483648) blend = -64'sd2147483648;
    acc = blend[31:0];
    exp_angle.push_back(16'(shr(blend, 16)));
    exp_tilt.push_back(14'(tilt));
    exp_rate.push_back(rate);
  endfunction

  function void check_result(logic [15:0] angle, logic [13:0] tilt, logic [15:0] rate);
    if (exp_angle.size() == 0) begin
      $error("unexpected result transaction");
      errors++;
      return;
    end
    if (angle !== exp_angle[0]) begin
      $error("filtered_angle expected %0d got %0d",
             $signed(exp_angle[0]), $signed(angle));
      errors++;
    end
    if (tilt !== exp_tilt[0]) begin
      $error("tilt_angle expected %0d got %0d", $signed(exp_tilt[0]), $signed(tilt));
      errors++;
    end
    if (rate !== exp_rate[0]) begin
      $error("last_rate expected %0d got %0d", $signed(exp_rate[0]), $signed(rate));
      errors++;
    end
    void'(exp_angle.pop_front());
    void'(exp_tilt.pop_front());
    void'(exp_rate.pop_front());
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0, rate_x = '0;
  logic [15:0] time_step = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] filtered_angle, last_rate;
  logic signed [13:0] tilt_angle;

  tilt_scoreboard board = new();
  bit quiet = 0;       // no idling in the last part
  bit hold_long = 0;   // request for a long receiver hold-off
  longint cycles = 0;

  complementary_tilt_filter_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .rate_x(rate_x), .time_step(time_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .filtered_angle(filtered_angle), .tilt_angle(tilt_angle), .last_rate(last_rate)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check results and note accepted samples, both sampled at the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(filtered_angle, tilt_angle, last_rate);
    if (!rst && in_valid && !in_stall)
      board.note_sample(accel_x, accel_y, accel_z, rate_x, time_step);
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                      logic [15:0] rate, logic [15:0] dt);
    accel_x <= ax;
    accel_y <= ay;
    accel_z <= az;
    rate_x <= rate;
    time_step <= dt;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // drop valid only if a gap follows; the next send keeps it high
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.exp_angle.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_alpha(logic [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    board.alpha = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] edgy();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(edgy(), edgy(), edgy(), edgy(), edgy());
      else if ($urandom_range(0, 19) == 0)
        send(16'h0000, 16'($urandom), 16'h0000, 16'($urandom), 16'($urandom));
      else
        send(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, zero magnitude, zero y, saturation.
    send(16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'hff00, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0100, 16'h0000, 16'h0300, 16'h0000, 16'h0000);
    send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
    send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    send(16'h0001, 16'h7fff, 16'h0000, 16'h7fff, 16'hffff);
    send(16'h8000, 16'h0001, 16'h0001, 16'h8000, 16'hffff);
    drain();
    set_alpha(16'hffff);
    for (int i = 0; i < 6; i++) send(16'h0000, 16'h0000, 16'h0001, 16'h7fff, 16'hffff);
    for (int i = 0; i < 8; i++) send(16'h0000, 16'h0000, 16'h0001, 16'h8000, 16'hffff);
    drain();
    set_alpha(16'h0000);
    send(16'h1234, 16'h8000, 16'h0000, 16'h7fff, 16'hffff);
    send(16'h0000, 16'h7fff, 16'hffff, 16'h0001, 16'h0001);
    drain();

    set_alpha(ctf_pkg::ALPHA_RESET);
    random_phase(400);
    // Fill the block while the receiver holds off.
    hold_long = 1;
    random_phase(20);
    drain();   // sender pauses until every result is back
    set_alpha(16'($urandom));
    random_phase(400);
    drain();
    set_alpha(16'h8000);
    random_phase(400);
    drain();
    set_alpha(16'hffff);
    quiet = 1;
    random_phase(350);
    drain();

    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ctf_pkg.sv
hw/rtl/ctf_datapath.sv
hw/rtl/ctf_ctrl.sv
hw/rtl/complementary_tilt_filter_top.sv
hw/rtl/ctf_checker.sv
tb/testbench.sv
